// ===== hdl/iwsm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IUPAC substring match package
// Shared payload types, register indexes and the base encoding.
// ----------------------------------------------------------------------------
package iwsm_pkg;

  localparam int unsigned MASK_W  = 64;
  localparam int unsigned PLEN_W  = 5;
  localparam int unsigned CODE_W  = 4;
  localparam int unsigned BASE_W  = 8;
  localparam int unsigned CIDX_W  = 1;

  localparam logic [CIDX_W-1:0] REG_PATTERN_MASKS  = 1'b0;
  localparam logic [CIDX_W-1:0] REG_PATTERN_LENGTH = 1'b1;

  localparam logic [BASE_W-1:0] CHAR_A = 8'h41;
  localparam logic [BASE_W-1:0] CHAR_C = 8'h43;
  localparam logic [BASE_W-1:0] CHAR_G = 8'h47;
  localparam logic [BASE_W-1:0] CHAR_T = 8'h54;

  localparam logic [CODE_W-1:0] CODE_A    = 4'b0001;
  localparam logic [CODE_W-1:0] CODE_C    = 4'b0010;
  localparam logic [CODE_W-1:0] CODE_G    = 4'b0100;
  localparam logic [CODE_W-1:0] CODE_T    = 4'b1000;
  localparam logic [CODE_W-1:0] CODE_NONE = 4'b0000;

  typedef struct packed {
    logic [BASE_W-1:0] base;
    logic              last;
  } iwsm_in_t;

  typedef struct packed {
    logic found;
  } iwsm_out_t;

  typedef struct packed {
    logic [CIDX_W-1:0] index;
    logic [MASK_W-1:0] data;
  } iwsm_cfg_t;

  typedef struct packed {
    logic              step;
    logic              clear;
    logic [CODE_W-1:0] code;
  } iwsm_cell_ctrl_t;

  // One-hot base code; every byte other than upper-case A, C, G, T maps to none.
  function automatic logic [CODE_W-1:0] base_code(input logic [BASE_W-1:0] ch);
    logic [CODE_W-1:0] code;
    case (ch)
      CHAR_A:  code = CODE_A;
      CHAR_C:  code = CODE_C;
      CHAR_G:  code = CODE_G;
      CHAR_T:  code = CODE_T;
      default: code = CODE_NONE;
    endcase
    return code;
  endfunction

endpackage

// ===== hdl/iwsm_stream_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Valid/ready channel
// Generic handshake channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface iwsm_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/iupac_wildcard_substring_match.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IUPAC wildcard substring match
// Reports whether a streamed DNA sequence contains the configured IUPAC query.
// ----------------------------------------------------------------------------
// The block accepts one sequence byte per cycle and returns one found
// transaction on the cycle after each byte marked last. Each of MAX_QUERY
// cells holds one active-prefix bit and is updated from its neighbor on every
// accepted byte, so throughput is one byte per cycle whenever the output
// register is empty or being drained. An empty query matches every sequence,
// and lengths above MAX_QUERY saturate. Configuration writes are always ready.
module iupac_wildcard_substring_match
  import iwsm_pkg::*;
#(
  parameter int unsigned MAX_QUERY = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  iwsm_stream_if.sink      cfg_i,
  iwsm_stream_if.sink      in_i,
  iwsm_stream_if.source    out_o
);

  localparam int unsigned LEN_W = $clog2(MAX_QUERY + 1);

  logic [MASK_W-1:0] masks_q;
  logic [PLEN_W-1:0] plen_q;
  logic [LEN_W-1:0]  len_eff;

  logic              seen_q, seen_d;
  logic              out_valid_q, out_valid_d;
  logic              out_found_q, out_found_d;

  logic              in_fire;
  logic              found_now;
  logic              match;
  iwsm_cell_ctrl_t   ctrl;

  logic [MAX_QUERY-1:0] en_vec;
  logic [MAX_QUERY-1:0] tail_vec;
  logic [MAX_QUERY-1:0] act_vec;
  logic [MAX_QUERY-1:0] next_vec;
  logic [MAX_QUERY-1:0] prev_vec;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      masks_q <= '0;
      plen_q  <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.data.index)
        REG_PATTERN_MASKS:  masks_q <= cfg_i.data.data;
        REG_PATTERN_LENGTH: plen_q  <= cfg_i.data.data[PLEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign len_eff = (32'(plen_q) > MAX_QUERY) ? LEN_W'(MAX_QUERY) : LEN_W'(plen_q);

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_fire    = in_i.valid && in_i.ready;

  assign ctrl = '{step: in_fire, clear: in_i.data.last, code: base_code(in_i.data.base)};

  for (genvar i = 0; i < MAX_QUERY; i++) begin : g_cell
    assign en_vec[i]   = LEN_W'(i) < len_eff;
    assign tail_vec[i] = len_eff == LEN_W'(i + 1);
    if (i == 0) begin : g_head
      assign prev_vec[i] = 1'b1;
    end else begin : g_body
      assign prev_vec[i] = act_vec[i-1];
    end

    iwsm_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl),
      .mask_i   (masks_q[CODE_W*i +: CODE_W]),
      .en_i     (en_vec[i]),
      .prev_i   (prev_vec[i]),
      .active_o (act_vec[i]),
      .next_o   (next_vec[i])
    );
  end

  assign match     = |(next_vec & tail_vec);
  assign found_now = seen_q || (len_eff == '0) || match;

  always_comb begin
    seen_d      = seen_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_found_d = out_found_q;
    if (in_fire) begin
      if (in_i.data.last) begin
        seen_d      = 1'b0;
        out_valid_d = 1'b1;
        out_found_d = found_now;
      end else begin
        seen_d = found_now;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_found_q <= 1'b0;
    end else begin
      seen_q      <= seen_d;
      out_valid_q <= out_valid_d;
      out_found_q <= out_found_d;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.data.found = out_found_q;

  a_empty_query_found : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_i.data.last && (len_eff == '0) |=> out_valid_q && out_found_q)
    else $error("Empty query did not report found.");

  a_clear_after_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_i.data.last |=> (act_vec == '0) && !seen_q)
    else $error("Match state not cleared after last byte.");

  a_unused_cells_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (act_vec & ~$past(en_vec)) == '0)
    else $error("Cell beyond query length holds an active prefix.");

  a_no_overrun : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_o.ready |-> !in_i.ready)
    else $error("Input accepted while result is stalled.");

endmodule

// ===== hdl/iwsm_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shift-and cell
// Holds one active-prefix bit and extends it from the neighbor on each base.
// ----------------------------------------------------------------------------
module iwsm_cell
  import iwsm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  iwsm_cell_ctrl_t   ctrl_i,
  input  logic [CODE_W-1:0] mask_i,
  input  logic              en_i,
  input  logic              prev_i,
  output logic              active_o,
  output logic              next_o
);

  logic active_q;
  logic active_d;

  assign next_o = en_i & prev_i & (|(mask_i & ctrl_i.code));

  always_comb begin
    active_d = active_q;
    if (ctrl_i.step) begin
      active_d = ctrl_i.clear ? 1'b0 : next_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
    end else begin
      active_q <= active_d;
    end
  end

  assign active_o = active_q;

endmodule
